/* rtl/shortest_path_max_distance_top_defines.svh */
// Assertion macros for the shortest path block checker.
// No dependencies; included by the checker file.
`ifndef SHORTEST_PATH_MAX_DISTANCE_TOP_DEFINES_SVH
`define SHORTEST_PATH_MAX_DISTANCE_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPMD_ASSERT_NOW(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("spmd assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SPMD_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("spmd assertion failed");

`endif

/* rtl/spmd_pkg.sv */
// Shared types and constants for the shortest path block.
// No dependencies; used by every file except the assertion macro header.
`default_nettype none

package spmd_pkg;

    localparam int NODES_DEFAULT = 32;
    localparam int NODE_W        = 5;
    localparam int WEIGHT_W      = 27;
    localparam int EDGE_W        = WEIGHT_W + 1;
    localparam int DIST_W        = 32;

    localparam logic [WEIGHT_W-1:0] WEIGHT_LIMIT = WEIGHT_W'(100000000);

    // edge entry: valid bit above the weight
    localparam logic [EDGE_W-1:0] EDGE_DIAG = {1'b1, {WEIGHT_W{1'b0}}};
    localparam logic [EDGE_W-1:0] EDGE_NONE = '0;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_RUN    = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REJECT  = 2'd1;
    localparam logic [1:0] ST_UNREACH = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    typedef struct packed {
        logic [1:0]          op;
        logic [NODE_W-1:0]   node_a;
        logic [NODE_W-1:0]   node_b;
        logic [WEIGHT_W-1:0] edge_weight;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [DIST_W-1:0] max_distance;
    } rsp_t;

endpackage

`default_nettype wire

/* rtl/shortest_path_max_distance_top.sv */
// Shortest path block: edge table, Bellman-Ford sequencer, result register.
// Depends on spmd_pkg and spmd_ram.
`default_nettype none

// Usage
// req channel: one item per command (clear, add edge, run). req_stall is high
//   whenever the sequencer is busy, so one item is worked on at a time.
// rsp channel: exactly one item per request, in order. A finished result sits
//   in an output register; the next request may be accepted while it waits.
// clear: one edge table entry is written per cycle.
// add edge: two writes through the single edge table port.
// run: the relaxation loop checks one edge per cycle through the pipelined
//   add/compare unit, drained between source nodes; unreachable sources skip.
// Reset: the edge table is swept to no-edge with a zero diagonal, one entry
//   per cycle, with req_stall held high.
// While rsp_stall is high the result holds; a later result waits in the
//   sequencer until the output register frees.

module shortest_path_max_distance_top #(
    parameter int NODES = spmd_pkg::NODES_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  spmd_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output spmd_pkg::rsp_t rsp
);

    localparam int NW         = $clog2(NODES);
    localparam int EDGE_DEPTH = NODES << NW;
    localparam int DW         = spmd_pkg::DIST_W;
    localparam int WW         = spmd_pkg::WEIGHT_W;
    localparam int EW         = spmd_pkg::EDGE_W;
    localparam logic [NW-1:0] LAST_NODE = NW'(NODES - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD2,
        S_INIT,
        S_ULOAD,
        S_UWAIT,
        S_SWEEP,
        S_DRAIN,
        S_FIN_RD,
        S_FIN_CHK,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [NW-1:0]     cu_reg, cu_next;
    logic [NW-1:0]     cv_reg, cv_next;
    logic [NW-1:0]     round_reg, round_next;
    logic [NW-1:0]     hi_reg, hi_next;
    logic [NODES-1:0]  reach_reg, reach_next;
    logic [DW-1:0]     bu_reg, bu_next;
    logic              clr_rsp_reg, clr_rsp_next;
    logic [NW-1:0]     pa_reg, pa_next;
    logic [NW-1:0]     pb_reg, pb_next;
    logic [WW-1:0]     pw_reg, pw_next;
    logic              p1_valid_reg, p1_valid_next;
    logic [NW-1:0]     p1_v_reg, p1_v_next;
    logic              p2_valid_reg, p2_valid_next;
    logic [NW-1:0]     p2_v_reg, p2_v_next;
    logic [DW-1:0]     p2_cand_reg, p2_cand_next;
    logic [DW-1:0]     p2_best_reg, p2_best_next;
    logic [DW-1:0]     max_reg, max_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic              rsp_valid_reg, rsp_valid_next;
    spmd_pkg::rsp_t    rsp_reg, rsp_next;

    logic              ewe;
    logic [2*NW-1:0]   ewaddr;
    logic [EW-1:0]     ewdata;
    logic [2*NW-1:0]   eraddr;
    logic [EW-1:0]     erdata;
    logic              bwe;
    logic [NW-1:0]     bwaddr;
    logic [DW-1:0]     bwdata;
    logic [NW-1:0]     braddr;
    logic [DW-1:0]     brdata;

    logic [NW-1:0]     a_idx, b_idx, hi_a;
    logic              a_in, b_in;
    logic [DW:0]       sum;
    logic [DW-1:0]     cand, fin_max;
    state_t            adv_state;
    logic [NW-1:0]     adv_cu, adv_cv, adv_round;

    spmd_ram #(.WIDTH(EW), .DEPTH(EDGE_DEPTH)) u_edge_ram (
        .clk   (clk),
        .we    (ewe),
        .waddr (ewaddr),
        .wdata (ewdata),
        .raddr (eraddr),
        .rdata (erdata)
    );

    spmd_ram #(.WIDTH(DW), .DEPTH(NODES)) u_best_ram (
        .clk   (clk),
        .we    (bwe),
        .waddr (bwaddr),
        .wdata (bwdata),
        .raddr (braddr),
        .rdata (brdata)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign a_idx = NW'(req.node_a);
    assign b_idx = NW'(req.node_b);
    assign a_in  = (32'(req.node_a) < 32'(NODES));
    assign b_in  = (32'(req.node_b) < 32'(NODES));
    assign hi_a  = (a_idx > hi_reg) ? a_idx : hi_reg;

    // shared relaxation unit: saturating add of best[u] and the edge weight
    assign sum  = {1'b0, bu_reg} + (DW + 1)'(erdata[WW-1:0]);
    assign cand = sum[DW] ? '1 : sum[DW-1:0];

    assign fin_max = (brdata > max_reg) ? brdata : max_reg;

    // step to the next source node, or to the next round, or to the scan
    always_comb
    begin
        adv_cu    = cu_reg + NW'(1);
        adv_cv    = cv_reg;
        adv_round = round_reg;
        adv_state = S_ULOAD;
        if (cu_reg == hi_reg)
        begin
            adv_cu = '0;
            if (round_reg == hi_reg - NW'(1))
            begin
                adv_cv    = NW'(1);
                adv_state = S_FIN_RD;
            end
            else
            begin
                adv_round = round_reg + NW'(1);
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cu_next         = cu_reg;
        cv_next         = cv_reg;
        round_next      = round_reg;
        hi_next         = hi_reg;
        reach_next      = reach_reg;
        bu_next         = bu_reg;
        clr_rsp_next    = clr_rsp_reg;
        pa_next         = pa_reg;
        pb_next         = pb_reg;
        pw_next         = pw_reg;
        max_next        = max_reg;
        res_status_next = res_status_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg;

        ewe    = 1'b0;
        ewaddr = {pa_reg, pb_reg};
        ewdata = {1'b1, pw_reg};
        eraddr = {cu_reg, cv_reg};
        bwe    = 1'b0;
        bwaddr = p2_v_reg;
        bwdata = p2_cand_reg;
        braddr = cv_reg;

        // relaxation pipeline: stage 1 adds, stage 2 compares and writes back
        p1_valid_next = 1'b0;
        p1_v_next     = cv_reg;
        p2_valid_next = p1_valid_reg && erdata[WW];
        p2_v_next     = p1_v_reg;
        p2_cand_next  = cand;
        p2_best_next  = brdata;
        if (p2_valid_reg && (!reach_reg[p2_v_reg] || (p2_cand_reg < p2_best_reg)))
        begin
            bwe                  = 1'b1;
            reach_next[p2_v_reg] = 1'b1;
        end

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                ewe    = 1'b1;
                ewaddr = {cu_reg, cv_reg};
                ewdata = (cu_reg == cv_reg) ? spmd_pkg::EDGE_DIAG : spmd_pkg::EDGE_NONE;
                cv_next = cv_reg + NW'(1);
                if (cv_reg == LAST_NODE)
                begin
                    cv_next = '0;
                    cu_next = cu_reg + NW'(1);
                    if (cu_reg == LAST_NODE)
                    begin
                        cu_next         = '0;
                        res_status_next = spmd_pkg::ST_OK;
                        max_next        = '0;
                        state_next      = clr_rsp_reg ? S_DONE : S_IDLE;
                    end
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    res_status_next = spmd_pkg::ST_OK;
                    max_next        = '0;
                    state_next      = S_DONE;
                    case (req.op)
                        spmd_pkg::OP_CLEAR:
                        begin
                            hi_next      = '0;
                            cu_next      = '0;
                            cv_next      = '0;
                            clr_rsp_next = 1'b1;
                            state_next   = S_CLEAR;
                        end
                        spmd_pkg::OP_ADD:
                        begin
                            if (req.edge_weight > spmd_pkg::WEIGHT_LIMIT)
                            begin
                                res_status_next = spmd_pkg::ST_REJECT;
                            end
                            else if (a_in && b_in)
                            begin
                                ewe        = 1'b1;
                                ewaddr     = {a_idx, b_idx};
                                ewdata     = {1'b1, req.edge_weight};
                                pa_next    = a_idx;
                                pb_next    = b_idx;
                                pw_next    = req.edge_weight;
                                hi_next    = (b_idx > hi_a) ? b_idx : hi_a;
                                state_next = S_ADD2;
                            end
                        end
                        spmd_pkg::OP_RUN:
                        begin
                            if (hi_reg == '0)
                            begin
                                res_status_next = spmd_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_INIT;
                            end
                        end
                        default:
                        begin
                            res_status_next = spmd_pkg::ST_OK;
                        end
                    endcase
                end
            end

            S_ADD2:
            begin
                ewe        = 1'b1;
                ewaddr     = {pb_reg, pa_reg};
                state_next = S_DONE;
            end

            S_INIT:
            begin
                reach_next    = '0;
                reach_next[0] = 1'b1;
                bwe           = 1'b1;
                bwaddr        = '0;
                bwdata        = '0;
                cu_next       = '0;
                round_next    = '0;
                max_next      = '0;
                state_next    = S_ULOAD;
            end

            S_ULOAD:
            begin
                if (reach_reg[cu_reg])
                begin
                    braddr     = cu_reg;
                    state_next = S_UWAIT;
                end
                else
                begin
                    cu_next    = adv_cu;
                    cv_next    = adv_cv;
                    round_next = adv_round;
                    state_next = adv_state;
                end
            end

            S_UWAIT:
            begin
                bu_next    = brdata;
                cv_next    = '0;
                state_next = S_SWEEP;
            end

            S_SWEEP:
            begin
                p1_valid_next = 1'b1;
                cv_next       = cv_reg + NW'(1);
                if (cv_reg == hi_reg)
                begin
                    state_next = S_DRAIN;
                end
            end

            S_DRAIN:
            begin
                // best[] must be settled before the next source reads it
                if (!p1_valid_reg && !p2_valid_reg)
                begin
                    cu_next    = adv_cu;
                    cv_next    = adv_cv;
                    round_next = adv_round;
                    state_next = adv_state;
                end
            end

            S_FIN_RD:
            begin
                if (!reach_reg[cv_reg])
                begin
                    res_status_next = spmd_pkg::ST_UNREACH;
                    max_next        = '0;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_FIN_CHK;
                end
            end

            S_FIN_CHK:
            begin
                max_next = fin_max;
                if (cv_reg == hi_reg)
                begin
                    res_status_next = spmd_pkg::ST_OK;
                    state_next      = S_DONE;
                end
                else
                begin
                    cv_next    = cv_reg + NW'(1);
                    state_next = S_FIN_RD;
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.status       = res_status_reg;
                    rsp_next.max_distance = max_reg;
                    clr_rsp_next          = 1'b0;
                    state_next            = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            cu_reg         <= '0;
            cv_reg         <= '0;
            round_reg      <= '0;
            hi_reg         <= '0;
            reach_reg      <= '0;
            bu_reg         <= '0;
            clr_rsp_reg    <= 1'b0;
            pa_reg         <= '0;
            pb_reg         <= '0;
            pw_reg         <= '0;
            p1_valid_reg   <= 1'b0;
            p1_v_reg       <= '0;
            p2_valid_reg   <= 1'b0;
            p2_v_reg       <= '0;
            p2_cand_reg    <= '0;
            p2_best_reg    <= '0;
            max_reg        <= '0;
            res_status_reg <= spmd_pkg::ST_OK;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cu_reg         <= cu_next;
            cv_reg         <= cv_next;
            round_reg      <= round_next;
            hi_reg         <= hi_next;
            reach_reg      <= reach_next;
            bu_reg         <= bu_next;
            clr_rsp_reg    <= clr_rsp_next;
            pa_reg         <= pa_next;
            pb_reg         <= pb_next;
            pw_reg         <= pw_next;
            p1_valid_reg   <= p1_valid_next;
            p1_v_reg       <= p1_v_next;
            p2_valid_reg   <= p2_valid_next;
            p2_v_reg       <= p2_v_next;
            p2_cand_reg    <= p2_cand_next;
            p2_best_reg    <= p2_best_next;
            max_reg        <= max_next;
            res_status_reg <= res_status_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_reg        <= rsp_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/spmd_ram.sv */
// Generic single write port, single read port RAM with registered read.
// No dependencies beyond the package defaults.
`default_nettype none

module spmd_ram #(
    parameter int WIDTH = spmd_pkg::EDGE_W,
    parameter int DEPTH = spmd_pkg::NODES_DEFAULT,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/spmd_checker.sv */
// Port-level checks for the shortest path block, bound to the top level.
// Depends on spmd_pkg and shortest_path_max_distance_top_defines.svh.
`default_nettype none
`include "shortest_path_max_distance_top_defines.svh"

module spmd_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           req_valid,
    input wire logic           req_stall,
    input wire spmd_pkg::req_t req,
    input wire logic           rsp_valid,
    input wire logic           rsp_stall,
    input wire spmd_pkg::rsp_t rsp
);

    // a stalled result stays up and unchanged
    `SPMD_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid)
    `SPMD_ASSERT_NEXT(a_rsp_stable, clk, rst_n, rsp_valid && rsp_stall, $stable(rsp))

    // every accepted item leaves the sequencer busy in the following cycle
    `SPMD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req_valid && !req_stall, req_stall)

    // a new result only appears out of a busy sequencer
    `SPMD_ASSERT_NOW(a_rsp_from_busy, clk, rst_n, $rose(rsp_valid), $past(req_stall))

endmodule

bind shortest_path_max_distance_top spmd_checker u_spmd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire

/* bench/spmd_bench_pkg.sv */
// Scoreboard for the shortest path block: keeps its own copy of the edge table,
// works out the response to each accepted request and checks responses in order.
// Depends on spmd_pkg.
package spmd_bench_pkg;

    // opcode 3 has no name in the design package; the block only answers it with status OK
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int GRAPH_NODES      = spmd_pkg::NODES_DEFAULT;
    localparam int REPORT_LIMIT     = 10;

    class path_scoreboard;

        logic [spmd_pkg::EDGE_W-1:0] link_tab [GRAPH_NODES*GRAPH_NODES];
        logic [spmd_pkg::NODE_W-1:0] top_node;
        spmd_pkg::rsp_t              pending_rsp [$];
        int                          mismatches;
        int                          checked;
        int                          n_clear, n_add, n_reject, n_spare;
        int                          n_run, n_ok, n_unreach, n_empty;

        function new();
            wipe_graph();
        endfunction

        function void wipe_graph();
            int i;
            for (i = 0; i < GRAPH_NODES * GRAPH_NODES; i++)
                link_tab[i] = spmd_pkg::EDGE_NONE;
            for (i = 0; i < GRAPH_NODES; i++)
                link_tab[i * GRAPH_NODES + i] = spmd_pkg::EDGE_DIAG;
            top_node = '0;
        endfunction

        function void note_request(spmd_pkg::req_t r);
            spmd_pkg::rsp_t              want;
            logic [spmd_pkg::DIST_W-1:0] path_len [GRAPH_NODES];
            bit                          seen [GRAPH_NODES];
            logic [spmd_pkg::EDGE_W-1:0] link;
            logic [spmd_pkg::DIST_W:0]   sum;
            logic [spmd_pkg::DIST_W-1:0] cand;
            int                          h, k, u, v;
            want = '0;
            case (r.op)
                spmd_pkg::OP_CLEAR:
                begin
                    wipe_graph();
                    n_clear++;
                end
                spmd_pkg::OP_ADD:
                begin
                    n_add++;
                    if (r.edge_weight > spmd_pkg::WEIGHT_LIMIT)
                    begin
                        want.status = spmd_pkg::ST_REJECT;
                        n_reject++;
                    end
                    else
                    begin
                        link_tab[r.node_a * GRAPH_NODES + r.node_b] = {1'b1, r.edge_weight};
                        link_tab[r.node_b * GRAPH_NODES + r.node_a] = {1'b1, r.edge_weight};
                        if (r.node_a > top_node)
                            top_node = r.node_a;
                        if (r.node_b > top_node)
                            top_node = r.node_b;
                    end
                end
                spmd_pkg::OP_RUN:
                begin
                    n_run++;
                    h = int'(top_node);
                    if (h == 0)
                    begin
                        want.status = spmd_pkg::ST_EMPTY;
                        n_empty++;
                    end
                    else
                    begin
                        for (v = 0; v < GRAPH_NODES; v++)
                        begin
                            path_len[v] = '0;
                            seen[v]     = 1'b0;
                        end
                        seen[0] = 1'b1;
                        // h rounds of relaxation; missing links stay infinite
                        for (k = 0; k < h; k++)
                            for (u = 0; u <= h; u++)
                                if (seen[u])
                                    for (v = 0; v <= h; v++)
                                    begin
                                        link = link_tab[u * GRAPH_NODES + v];
                                        if (link[spmd_pkg::EDGE_W-1])
                                        begin
                                            sum  = path_len[u] + link[spmd_pkg::WEIGHT_W-1:0];
                                            cand = sum[spmd_pkg::DIST_W] ? '1 :
                                                   sum[spmd_pkg::DIST_W-1:0];
                                            if (!seen[v] || cand < path_len[v])
                                            begin
                                                seen[v]     = 1'b1;
                                                path_len[v] = cand;
                                            end
                                        end
                                    end
                        for (v = 1; v <= h; v++)
                            if (!seen[v])
                                want.status = spmd_pkg::ST_UNREACH;
                            else if (path_len[v] > want.max_distance)
                                want.max_distance = path_len[v];
                        if (want.status == spmd_pkg::ST_UNREACH)
                        begin
                            want.max_distance = '0;
                            n_unreach++;
                        end
                        else
                            n_ok++;
                    end
                end
                default:
                    n_spare++;
            endcase
            pending_rsp.push_back(want);
        endfunction

        function void check_response(spmd_pkg::rsp_t got);
            spmd_pkg::rsp_t want;
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected response: status %0d distance %0d",
                             got.status, got.max_distance);
                return;
            end
            want = pending_rsp.pop_front();
            checked++;
            if (got.status !== want.status || got.max_distance !== want.max_distance)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"response %0d: expected status %0d distance %0d, ",
                              "got status %0d distance %0d"},
                             checked, want.status, want.max_distance,
                             got.status, got.max_distance);
            end
        endfunction

    endclass

endpackage

/* bench/tb.sv */
// Top of the shortest path bench: clock, reset, request driver and response sink.
// Depends on spmd_pkg, spmd_bench_pkg and shortest_path_max_distance_top.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int RANDOM_ITEMS  = 80;
    localparam int CALM_TAIL     = 20;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 1100;
    localparam int MAX_WEIGHT_OK = 100000000;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           rsp_stall = 1'b0;
    spmd_pkg::req_t req       = '0;
    logic           req_stall;
    logic           rsp_valid;
    spmd_pkg::rsp_t rsp;

    spmd_bench_pkg::path_scoreboard sb = new();

    bit calm         = 1'b0;
    bit hold_request = 1'b0;
    int cycle_count  = 0;
    int items_sent   = 0;
    int calm_from    = 1_000_000_000;

    shortest_path_max_distance_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    task automatic send(input logic [1:0] op, input int a, input int b, input int w);
        spmd_pkg::req_t item;
        item.op          = op;
        item.node_a      = a[spmd_pkg::NODE_W-1:0];
        item.node_b      = b[spmd_pkg::NODE_W-1:0];
        item.edge_weight = w[spmd_pkg::WEIGHT_W-1:0];
        if (items_sent >= calm_from)
            calm = 1'b1;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        sb.note_request(item);
        if (op != spmd_bench_pkg::OP_SPARE)
            items_sent++;
    endtask

    function automatic int pick_weight();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(MAX_WEIGHT_OK + 1, 134217727);
            1, 2, 3: return $urandom_range(0, 20);
            default: return $urandom_range(0, MAX_WEIGHT_OK);
        endcase
    endfunction

    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
                sb.check_response(rsp);
            if (stall_left > 0)
                stall_left--;
            else if (hold_request)
            begin
                // long hold so the sequencer backs up and stalls requests
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 16);
            rsp_stall <= (stall_left > 0);
        end
    end

    initial
    begin : stimulus
        int order [spmd_bench_pkg::GRAPH_NODES];
        int random_start, pick, span, prev, a, k, j, t, v;
        bit needs_clear, chain_done;
        needs_clear = 1'b0;
        chain_done  = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty graph, spare opcode, weight limit either side
        send(spmd_pkg::OP_RUN, 0, 0, 0);
        send(spmd_bench_pkg::OP_SPARE, 31, 31, 134217727);
        send(spmd_pkg::OP_ADD, 0, 1, MAX_WEIGHT_OK + 1);
        send(spmd_pkg::OP_ADD, 1, 2, 134217727);
        send(spmd_pkg::OP_ADD, 0, 1, MAX_WEIGHT_OK);
        send(spmd_pkg::OP_ADD, 2, 1, 0);
        send(spmd_pkg::OP_RUN, 0, 0, 0);             // node 2 only via node 1
        send(spmd_pkg::OP_ADD, 3, 3, 5);             // self link, node 3 cut off
        send(spmd_pkg::OP_RUN, 0, 0, 0);
        hold_request = 1'b1;
        send(spmd_pkg::OP_ADD, 3, 2, 7);
        send(spmd_pkg::OP_ADD, 0, 0, 9);             // overwrites the diagonal
        send(spmd_pkg::OP_ADD, 0, 3, 1);
        send(spmd_pkg::OP_ADD, 31, 16, 12345);
        send(spmd_pkg::OP_RUN, 0, 0, 0);
        send(spmd_pkg::OP_CLEAR, 0, 0, 0);
        send(spmd_pkg::OP_RUN, 0, 0, 0);
        send(spmd_pkg::OP_ADD, 0, 1, 1);
        send(spmd_pkg::OP_ADD, 1, 2, 1);
        send(spmd_pkg::OP_ADD, 0, 2, 5);             // longer than the two-hop route
        send(spmd_pkg::OP_RUN, 0, 0, 0);
        send(spmd_pkg::OP_CLEAR, 0, 0, 0);

        random_start = items_sent;
        calm_from    = random_start + RANDOM_ITEMS - CALM_TAIL;
        while (items_sent < random_start + RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (!chain_done && (pick == 0 || items_sent - random_start >= 30))
            begin
                // every node on one shuffled chain: deepest paths, largest sums
                chain_done = 1'b1;
                send(spmd_pkg::OP_CLEAR, 0, 0, 0);
                for (k = 1; k < spmd_bench_pkg::GRAPH_NODES; k++)
                    order[k] = k;
                for (k = spmd_bench_pkg::GRAPH_NODES - 1; k > 1; k--)
                begin
                    j        = $urandom_range(1, k);
                    t        = order[k];
                    order[k] = order[j];
                    order[j] = t;
                end
                prev = 0;
                for (k = 1; k < spmd_bench_pkg::GRAPH_NODES; k++)
                begin
                    if ($urandom_range(0, 1))
                        send(spmd_pkg::OP_ADD, prev, order[k],
                             $urandom_range(0, MAX_WEIGHT_OK));
                    else
                        send(spmd_pkg::OP_ADD, order[k], prev,
                             $urandom_range(0, MAX_WEIGHT_OK));
                    prev = order[k];
                end
                send(spmd_pkg::OP_RUN, 0, 0, 0);
                needs_clear = 1'b1;
            end
            else if (pick == 1)
            begin
                repeat ($urandom_range(1, 3))
                    send(2'($urandom_range(0, 3)), $urandom_range(0, 31),
                         $urandom_range(0, 31), $urandom & 32'h07FF_FFFF);
                needs_clear = 1'b1;
            end
            else
            begin
                // small graph, mostly a spanning tree with a few extra links
                span = $urandom_range(1, 7);
                if (needs_clear || $urandom_range(0, 3) != 0)
                    send(spmd_pkg::OP_CLEAR, 0, 0, 0);
                needs_clear = 1'b0;
                for (v = 1; v <= span; v++)
                    if ($urandom_range(0, 7) != 0)
                    begin
                        a = $urandom_range(0, v - 1);
                        if ($urandom_range(0, 1))
                            send(spmd_pkg::OP_ADD, a, v, pick_weight());
                        else
                            send(spmd_pkg::OP_ADD, v, a, pick_weight());
                    end
                repeat ($urandom_range(0, 3))
                    send(spmd_pkg::OP_ADD, $urandom_range(0, span), $urandom_range(0, span),
                         pick_weight());
                send(spmd_pkg::OP_RUN, 0, 0, 0);
            end
        end

        req_valid <= 1'b0;
        while (sb.pending_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Requests: %0d clears, %0d edge writes (%0d over the weight limit), %0d spare",
                 sb.n_clear, sb.n_add, sb.n_reject, sb.n_spare);
        $display("Path runs: %0d, %0d reachable, %0d cut off, %0d empty; %0d checked",
                 sb.n_run, sb.n_ok, sb.n_unreach, sb.n_empty, sb.checked);
        if (sb.mismatches == 0 && sb.pending_rsp.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
